// File: rtl/rcfd_pkg.sv
// Package with shared widths, register indexes and decode helpers for the frame decoder.
`timescale 1ns / 1ps
package rcfd_pkg;

    localparam int FRAME_BYTES_DEF = 18;
    localparam int DEC_BYTES       = 18;
    localparam int CH_W            = 11;
    localparam int SW_W            = 2;
    localparam int AXIS_W          = 16;
    localparam int BK_W            = 32;
    localparam int LIM_W           = 15;
    localparam int DB_W            = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int S_TDATA_W       = 8;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 144;
    localparam int M_TUSER_W       = 1;

    localparam logic [CH_W-1:0]  CENTER        = 11'd1024;
    localparam logic [CH_W-1:0]  CH_MIN_RST    = 11'd364;
    localparam logic [CH_W-1:0]  CH_MAX_RST    = 11'd1684;
    localparam logic [DB_W-1:0]  DB_RST        = 8'd3;
    localparam logic [LIM_W-1:0] LIM_RST       = 15'd25000;
    localparam logic [SW_W-1:0]  SW_RST        = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CH_MIN   = 2'd0,
        CFG_CH_MAX   = 2'd1,
        CFG_DEADBAND = 2'd2,
        CFG_MOUSE_LIM = 2'd3
    } cfg_idx_t;

    typedef logic [7:0] byte_t;

    // Snap a channel to center when it lies within the deadband.
    function automatic logic [CH_W-1:0] snap_ch(input logic [CH_W-1:0] ch,
                                                input logic [DB_W-1:0] d);
        logic [CH_W:0] ch_x;
        logic [CH_W:0] d_x;
        logic [CH_W:0] c_x;
        ch_x = {1'b0, ch};
        d_x  = {{(CH_W+1-DB_W){1'b0}}, d};
        c_x  = {1'b0, CENTER};
        if ((ch_x + d_x >= c_x) && (ch_x <= c_x + d_x)) begin
            snap_ch = CENTER;
        end else begin
            snap_ch = ch;
        end
    endfunction

    // Clamp a signed axis to plus or minus the limit.
    function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] v,
                                                     input logic [LIM_W-1:0] lim);
        logic signed [AXIS_W:0] v_x;
        logic signed [AXIS_W:0] l_x;
        logic signed [AXIS_W:0] nl_x;
        v_x  = signed'({v[AXIS_W-1], v});
        l_x  = signed'({2'b00, lim});
        nl_x = -l_x;
        if (v_x > l_x) begin
            clamp_axis = l_x[AXIS_W-1:0];
        end else if (v_x < nl_x) begin
            clamp_axis = nl_x[AXIS_W-1:0];
        end else begin
            clamp_axis = v;
        end
    endfunction

endpackage

// File: rtl/rc_receiver_frame_decoder_unit.sv
// Remote-control receiver frame decoder: byte collection, field decode, checks and held values.
// The last byte of a frame sets a pending flag; the result word is registered from it once the output is free.
// Throughput: one input word per cycle when not stalled; a frame of FRAME_BYTES words gives one result word.
// Input is stalled only while a decoded result waits and the output word is not taken.
// Reset is synchronous and active low; it clears the byte count, the output valid,
// restores the register defaults and sets the held values to center, 3 and zero.
`timescale 1ns / 1ps
module rc_receiver_frame_decoder_unit
    import rcfd_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,   // frame_start, hold_ch0
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // stick_ch0..3, switch_left, switch_right,
                                             // wheel, mouse_x, mouse_y, mouse_z,
                                             // buttons_keys, zero fill
    output logic [M_TUSER_W-1:0]  m_tuser,   // frame_valid
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

    logic [CH_W-1:0]  ch_min_reg;
    logic [CH_W-1:0]  ch_max_reg;
    logic [DB_W-1:0]  db_reg;
    logic [LIM_W-1:0] lim_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_base;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_last;
    byte_t            fb_reg [DEC_BYTES];

    logic             pend_reg;
    logic             hold_reg;
    logic             m_tvalid_reg;
    logic             fvalid_reg;

    logic [CH_W-1:0]   hch_reg [4];
    logic [CH_W-1:0]   wheel_reg;
    logic [SW_W-1:0]   hsl_reg;
    logic [SW_W-1:0]   hsr_reg;
    logic [AXIS_W-1:0] hmx_reg;
    logic [AXIS_W-1:0] hmy_reg;
    logic [AXIS_W-1:0] hmz_reg;
    logic [BK_W-1:0]   hbk_reg;

    logic             s_acc;
    logic             out_free;
    logic             dec_fire;
    logic [CH_W-1:0]  dch [4];
    logic [CH_W-1:0]  ch0_sel;
    logic [SW_W-1:0]  dsl;
    logic [SW_W-1:0]  dsr;
    logic             dok;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign dec_fire  = pend_reg && out_free;
    assign s_tready  = !pend_reg || out_free;
    assign s_acc     = s_tvalid && s_tready;

    assign cnt_base = s_tuser[0] ? '0 : cnt_reg;
    assign cnt_last = (cnt_base == LAST_IDX);
    assign cnt_next = cnt_last ? '0 : cnt_base + CNT_W'(1);

    assign dch[0] = {fb_reg[1][2:0], fb_reg[0]};
    assign dch[1] = {fb_reg[2][5:0], fb_reg[1][7:3]};
    assign dch[2] = {fb_reg[4][0], fb_reg[3], fb_reg[2][7:6]};
    assign dch[3] = {fb_reg[5][3:0], fb_reg[4][7:1]};
    assign dsl    = fb_reg[5][7:6];
    assign dsr    = fb_reg[5][5:4];

    always_comb begin
        dok = (dsl != '0) && (dsr != '0);
        for (int i = 0; i < 4; i++) begin
            if ((dch[i] < ch_min_reg) || (dch[i] > ch_max_reg)) begin
                dok = 1'b0;
            end
        end
    end

    assign ch0_sel = hold_reg ? hch_reg[0] : dch[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_min_reg <= CH_MIN_RST;
            ch_max_reg <= CH_MAX_RST;
            db_reg     <= DB_RST;
            lim_reg    <= LIM_RST;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CH_MIN:    ch_min_reg <= cfg_data[CH_W-1:0];
                CFG_CH_MAX:    ch_max_reg <= cfg_data[CH_W-1:0];
                CFG_DEADBAND:  db_reg     <= cfg_data[DB_W-1:0];
                CFG_MOUSE_LIM: lim_reg    <= cfg_data[LIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end
            if (s_acc && cnt_last) begin
                pend_reg <= 1'b1;
            end else if (dec_fire) begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int i = 0; i < DEC_BYTES; i++) begin
                if ({{(8-CNT_W){1'b0}}, cnt_base} == 8'(i)) begin
                    fb_reg[i] <= s_tdata;
                end
            end
            if (cnt_last) begin
                hold_reg <= s_tuser[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            fvalid_reg   <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                hch_reg[i] <= CENTER;
            end
            wheel_reg <= CENTER;
            hsl_reg   <= SW_RST;
            hsr_reg   <= SW_RST;
            hmx_reg   <= '0;
            hmy_reg   <= '0;
            hmz_reg   <= '0;
            hbk_reg   <= '0;
        end else begin
            if (dec_fire) begin
                m_tvalid_reg <= 1'b1;
                fvalid_reg   <= dok;
                if (dok) begin
                    hch_reg[0] <= snap_ch(ch0_sel, db_reg);
                    for (int i = 1; i < 4; i++) begin
                        hch_reg[i] <= snap_ch(dch[i], db_reg);
                    end
                    wheel_reg <= {fb_reg[17][2:0], fb_reg[16]};
                    hsl_reg   <= dsl;
                    hsr_reg   <= dsr;
                    hmx_reg   <= clamp_axis({fb_reg[7], fb_reg[6]}, lim_reg);
                    hmy_reg   <= clamp_axis({fb_reg[9], fb_reg[8]}, lim_reg);
                    hmz_reg   <= {fb_reg[11], fb_reg[10]};
                    hbk_reg   <= {fb_reg[13], fb_reg[12], fb_reg[15], fb_reg[14]};
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Held values change only when a new result word is loaded, so they form the output word.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = fvalid_reg;
    assign m_tdata  = {5'b0, hbk_reg, hmz_reg, hmy_reg, hmx_reg, wheel_reg, hsr_reg, hsl_reg,
                       hch_reg[3], hch_reg[2], hch_reg[1], hch_reg[0]};

endmodule

// File: rtl/rcfd_checker.sv
// Port-level checker for the frame decoder, bound to the top level.
`timescale 1ns / 1ps
module rcfd_checker
    import rcfd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Input is only stalled behind a result word that is not being taken.
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // An accepted frame always carries two nonzero switches.
    a_sw_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[45:44] != 2'd0) && (m_tdata[47:46] != 2'd0))
        else $error("accepted frame with a zero switch");

    // No result word right after reset.
    a_rst_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

bind rc_receiver_frame_decoder_unit rcfd_checker u_rcfd_checker (.*);
